>>> rtl/core/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the servo status packet parser.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 16;
  localparam int PARAM_DEPTH          = 10;
  localparam int IDX_W                = $clog2(PARAM_DEPTH);
  localparam int CNT_W                = 4;
  localparam int ADDR_W               = 3;
  localparam int DATA_W               = 32;
  localparam int REG_SEL_BIT          = 2;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // input commands
  localparam logic [1:0] CMD_BYTE     = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT  = 2'd1;
  localparam logic [1:0] CMD_LINE_ERR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TIMEOUT      = 3'd1;
  localparam logic [2:0] ST_LINE         = 3'd2;
  localparam logic [2:0] ST_BAD_PACKET   = 3'd3;
  localparam logic [2:0] ST_BAD_CHECKSUM = 3'd4;
  localparam logic [2:0] ST_DEVICE       = 3'd5;

  // register select (paddr bit 2)
  localparam logic REG_TARGET_ID      = 1'b0;
  localparam logic REG_PARAM_CAPACITY = 1'b1;

  typedef enum logic [1:0] {
    PUSH_ABORT,
    PUSH_FINAL,
    PUSH_PARAM
  } push_kind_t;

  typedef struct packed {
    logic       cap_id;
    logic       cap_len;
    logic       cap_err;
    logic       cap_param;
    logic       clr_count;
    logic       emit_clr;
    logic       emit_inc;
    logic       push;
    push_kind_t push_kind;
    logic [2:0] abort_status;
  } dp_cmd_t;

  typedef struct packed {
    logic is_sync;
    logic len_bad;
    logic hdr_bad;
    logic no_params;
    logic params_done;
    logic sum_ok;
    logic emit_last;
    logic slot_free;
  } dp_status_t;

endpackage

>>> rtl/core/ssp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_datapath
// Header registers, checksum, parameter buffer and the result register.
// ----------------------------------------------------------------------------
module ssp_datapath #(
  parameter int MAX_PACKET_BYTES = ssp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [7:0]               rx_byte,
  input  logic [7:0]               target_id,
  input  logic [3:0]               param_capacity,
  input  ssp_pkg::dp_cmd_t         cmd,
  output ssp_pkg::dp_status_t      sts,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [2:0]               status,
  output logic [7:0]               device_error,
  output logic [ssp_pkg::CNT_W-1:0] param_count,
  output logic [ssp_pkg::CNT_W-1:0] param_index,
  output logic [7:0]               param_byte,
  output logic                     last
);

  logic [7:0]               pkt_id;
  logic [7:0]               pkt_length;
  logic [7:0]               pkt_error;
  logic [7:0]               running_sum;
  logic [ssp_pkg::IDX_W-1:0] param_counter;
  logic [ssp_pkg::IDX_W-1:0] emit_idx;
  logic [7:0]               param_buffer [ssp_pkg::PARAM_DEPTH];

  logic [7:0] count;
  logic [2:0] good_status;
  logic [8:0] len_ext;

  assign count       = pkt_length - 8'd2;
  assign good_status = (pkt_error != 8'd0) ? ssp_pkg::ST_DEVICE : ssp_pkg::ST_OK;
  assign len_ext     = {1'b0, rx_byte};

  always_comb begin
    sts.is_sync     = (rx_byte == ssp_pkg::SYNC_BYTE);
    // length + 4 checked without wrap
    sts.len_bad     = (rx_byte < 8'd2) || ((len_ext + 9'd4) > 9'(MAX_PACKET_BYTES));
    sts.hdr_bad     = (pkt_id != target_id) ||
                      (count > {4'd0, param_capacity}) ||
                      (count > 8'(ssp_pkg::PARAM_DEPTH));
    sts.no_params   = (count == 8'd0);
    sts.params_done = (8'(param_counter) + 8'd1) >= count;
    sts.sum_ok      = (~running_sum == rx_byte);
    sts.emit_last   = (8'(emit_idx) + 8'd1) == count;
    sts.slot_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_id) begin
      pkt_id      <= rx_byte;
      running_sum <= rx_byte;
    end
    if (cmd.cap_len) begin
      pkt_length  <= rx_byte;
      running_sum <= running_sum + rx_byte;
    end
    if (cmd.cap_err) begin
      pkt_error   <= rx_byte;
      running_sum <= running_sum + rx_byte;
    end
    if (cmd.clr_count) begin
      param_counter <= '0;
    end
    if (cmd.cap_param) begin
      param_buffer[param_counter] <= rx_byte;
      running_sum                 <= running_sum + rx_byte;
      param_counter               <= param_counter + 1'b1;
    end
    if (cmd.emit_clr) begin
      emit_idx <= '0;
    end else if (cmd.emit_inc) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      unique case (cmd.push_kind)
        ssp_pkg::PUSH_ABORT: begin
          status       <= cmd.abort_status;
          device_error <= 8'd0;
          param_count  <= '0;
          param_index  <= '0;
          param_byte   <= 8'd0;
          last         <= 1'b1;
        end
        ssp_pkg::PUSH_FINAL: begin
          status       <= good_status;
          device_error <= pkt_error;
          param_count  <= '0;
          param_index  <= '0;
          param_byte   <= 8'd0;
          last         <= 1'b1;
        end
        ssp_pkg::PUSH_PARAM: begin
          status       <= good_status;
          device_error <= pkt_error;
          param_count  <= count[ssp_pkg::CNT_W-1:0];
          param_index  <= ssp_pkg::CNT_W'(emit_idx);
          param_byte   <= param_buffer[emit_idx];
          last         <= sts.emit_last;
        end
        default: begin
          status       <= cmd.abort_status;
          device_error <= 8'd0;
          param_count  <= '0;
          param_index  <= '0;
          param_byte   <= 8'd0;
          last         <= 1'b1;
        end
      endcase
    end
  end

  // only parameter bursts carry non-final results
  a_nonlast_has_params: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> (param_count != '0))
    else $error("non-final result without parameters");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && param_count != '0) |-> (param_index < param_count))
    else $error("parameter index beyond count");

endmodule

>>> rtl/core/ssp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_ctrl
// Packet phase state machine: sync hunt, header, parameters, result burst.
// ----------------------------------------------------------------------------
module ssp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          command,
  input  ssp_pkg::dp_status_t sts,
  output ssp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_SYNC1,
    S_SYNC2,
    S_ID,
    S_LEN,
    S_ERR,
    S_PARAM,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state != S_EMIT) && sts.slot_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    if (accept) begin
      unique case (command)
        ssp_pkg::CMD_TIMEOUT: begin
          cmd.push         = 1'b1;
          cmd.push_kind    = ssp_pkg::PUSH_ABORT;
          cmd.abort_status = ssp_pkg::ST_TIMEOUT;
          state_next       = S_SYNC1;
        end
        ssp_pkg::CMD_LINE_ERR: begin
          cmd.push         = 1'b1;
          cmd.push_kind    = ssp_pkg::PUSH_ABORT;
          cmd.abort_status = ssp_pkg::ST_LINE;
          state_next       = S_SYNC1;
        end
        ssp_pkg::CMD_BYTE: begin
          unique case (state)
            S_SYNC1: state_next = sts.is_sync ? S_SYNC2 : S_SYNC1;
            S_SYNC2: state_next = sts.is_sync ? S_ID : S_SYNC1;
            S_ID: begin
              cmd.cap_id = 1'b1;
              state_next = S_LEN;
            end
            S_LEN: begin
              cmd.cap_len = 1'b1;
              if (sts.len_bad) begin
                cmd.push         = 1'b1;
                cmd.push_kind    = ssp_pkg::PUSH_ABORT;
                cmd.abort_status = ssp_pkg::ST_BAD_PACKET;
                state_next       = S_SYNC1;
              end else begin
                state_next = S_ERR;
              end
            end
            S_ERR: begin
              cmd.cap_err = 1'b1;
              if (sts.hdr_bad) begin
                cmd.push         = 1'b1;
                cmd.push_kind    = ssp_pkg::PUSH_ABORT;
                cmd.abort_status = ssp_pkg::ST_BAD_PACKET;
                state_next       = S_SYNC1;
              end else begin
                cmd.clr_count = 1'b1;
                state_next    = sts.no_params ? S_CHECK : S_PARAM;
              end
            end
            S_PARAM: begin
              cmd.cap_param = 1'b1;
              if (sts.params_done) begin
                state_next = S_CHECK;
              end
            end
            S_CHECK: begin
              state_next = S_SYNC1;
              if (!sts.sum_ok) begin
                cmd.push         = 1'b1;
                cmd.push_kind    = ssp_pkg::PUSH_ABORT;
                cmd.abort_status = ssp_pkg::ST_BAD_CHECKSUM;
              end else if (sts.no_params) begin
                cmd.push      = 1'b1;
                cmd.push_kind = ssp_pkg::PUSH_FINAL;
              end else begin
                cmd.emit_clr = 1'b1;
                state_next   = S_EMIT;
              end
            end
            default: state_next = S_SYNC1;
          endcase
        end
        default: ; // unused command: no effect
      endcase
    end else if (state == S_EMIT && sts.slot_free) begin
      cmd.push      = 1'b1;
      cmd.push_kind = ssp_pkg::PUSH_PARAM;
      cmd.emit_inc  = 1'b1;
      if (sts.emit_last) begin
        state_next = S_SYNC1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SYNC1;
    end else begin
      state <= state_next;
    end
  end

  // a pending result must never be overwritten
  a_push_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> sts.slot_free)
    else $error("result pushed while result register full");

  a_emit_has_params: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> !sts.no_params)
    else $error("parameter burst with no parameters");

  a_burst_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !sts.emit_last) |=> (state == S_EMIT))
    else $error("parameter burst ended early");

endmodule

>>> rtl/core/servo_status_packet_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_status_packet_parser
// Parses servo bus status packets (sync, id, length, error, parameters,
// inverted-sum checksum) from a byte/event stream and emits one result per
// parameter byte, or a single result for empty or failed packets.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         in_valid/in_ready   command, rx_byte
//  result    out        out_valid/out_ready status, device_error, param_count,
//                                           param_index, param_byte, last
//  config    in         APB psel/penable    paddr, pwdata, prdata
//
//  One input item per cycle while the result register is free or being taken.
//  A good packet with parameters emits its results one per cycle from the parameter
//  buffer while the result register is free or being taken; input is held off until the last one is loaded.
//  Reset (rst, synchronous) returns to sync hunt; no clearing pass.
//  A stalled result blocks further input items only through the result register.
// ----------------------------------------------------------------------------
module servo_status_packet_parser #(
  parameter int MAX_PACKET_BYTES = ssp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2:0]                  status,
  output logic [7:0]                  device_error,
  output logic [3:0]                  param_count,
  output logic [3:0]                  param_index,
  output logic [7:0]                  param_byte,
  output logic                        last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssp_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssp_pkg::DATA_W-1:0]  pwdata,
  output logic [ssp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [7:0] target_id;
  logic [3:0] param_capacity;
  logic       reg_sel;

  ssp_pkg::dp_cmd_t    cmd;
  ssp_pkg::dp_status_t sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[ssp_pkg::REG_SEL_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      target_id      <= 8'd0;
      param_capacity <= 4'd2;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        ssp_pkg::REG_TARGET_ID:      target_id      <= pwdata[7:0];
        ssp_pkg::REG_PARAM_CAPACITY: param_capacity <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ssp_pkg::REG_TARGET_ID:      prdata = {{(ssp_pkg::DATA_W-8){1'b0}}, target_id};
      ssp_pkg::REG_PARAM_CAPACITY: prdata = {{(ssp_pkg::DATA_W-4){1'b0}}, param_capacity};
      default:                     prdata = '0;
    endcase
  end

  ssp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssp_datapath #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .rx_byte        (rx_byte),
    .target_id      (target_id),
    .param_capacity (param_capacity),
    .cmd            (cmd),
    .sts            (sts),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .status         (status),
    .device_error   (device_error),
    .param_count    (param_count),
    .param_index    (param_index),
    .param_byte     (param_byte),
    .last           (last)
  );

endmodule

>>> tb/servo_status_packet_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_status_packet_parser_tb
// Self-checking bench for the status packet parser. A queue-fed driver
// offers bus events (bytes, timeouts, line errors, unused codes) with random
// gaps, a receiver stalls at random and once holds off for a long stretch,
// and a monitor compares every result with a cycle-free model of the parser.
// Register settings change between traffic phases over APB, with read-back.
// ----------------------------------------------------------------------------
module servo_status_packet_parser_tb;

  localparam int PKT_MAX     = ssp_pkg::MAX_PACKET_BYTES_DEF;
  localparam int SETTLE_CYC  = 32;    // covers the longest result burst
  localparam int HOLD_CYC    = 300;
  localparam int QUIET_LIMIT = 2000;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, GET_ID, GET_LEN, GET_ERR, GET_PARAM, GET_SUM
  } rx_phase_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } bus_event_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] dev_err;
    logic [3:0] count;
    logic [3:0] index;
    logic [7:0] pbyte;
    logic       last;
  } status_report_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [1:0]                 command = ssp_pkg::CMD_BYTE;
  logic [7:0]                 rx_byte = 8'h00;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [2:0]                 status;
  logic [7:0]                 device_error;
  logic [3:0]                 param_count;
  logic [3:0]                 param_index;
  logic [7:0]                 param_byte;
  logic                       last;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [ssp_pkg::ADDR_W-1:0] paddr = '0;
  logic [ssp_pkg::DATA_W-1:0] pwdata = '0;
  logic [ssp_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  servo_status_packet_parser #(
    .MAX_PACKET_BYTES(PKT_MAX)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .command(command), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .device_error(device_error), .param_count(param_count), .param_index(param_index),
    .param_byte(param_byte), .last(last),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies and parser state of the model
  logic [7:0]     cfg_id = 8'h00;
  logic [3:0]     cfg_cap = 4'd2;
  rx_phase_t      rx_phase = HUNT_FIRST;
  logic [7:0]     rx_id, rx_len, rx_err, rx_sum;
  logic [3:0]     rx_nparam;
  logic [7:0]     rx_buf [ssp_pkg::PARAM_DEPTH];

  bus_event_t     bus_events_q[$];
  status_report_t status_reports_q[$];

  bus_event_t     next_ev;
  status_report_t want;
  logic           in_taken = 1'b0;
  bit             no_gaps = 1'b0;
  int             send_gap = 0;
  int             stall_left = 0;
  int             hold_left = 0;
  int             holds_asked = 0;
  int             holds_served = 0;
  int             quiet_cycles = 0;
  int             n_queued = 0;
  int             n_items = 0;
  int             n_results = 0;
  int             n_settings = 1;
  int             n_errors = 0;
  int             seen_status [6];

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, exp_val);
    n_errors++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_report(logic [2:0] st, logic [7:0] dev, logic [3:0] cnt,
                                      logic [3:0] idx, logic [7:0] pb, logic lst);
    status_reports_q.push_back('{st, dev, cnt, idx, pb, lst});
  endfunction

  // Advances the parser model by one bus event and queues the results it causes.
  task automatic parse_rx_event(input logic [1:0] cmd, input logic [7:0] b);
    logic [7:0] n_par;
    logic [2:0] st;
    int         i;
    n_par = rx_len - 8'd2;
    if (cmd == ssp_pkg::CMD_TIMEOUT || cmd == ssp_pkg::CMD_LINE_ERR) begin
      rx_phase = HUNT_FIRST;
      st = (cmd == ssp_pkg::CMD_TIMEOUT) ? ssp_pkg::ST_TIMEOUT : ssp_pkg::ST_LINE;
      push_report(st, 8'h00, 4'd0, 4'd0, 8'h00, 1'b1);
    end else if (cmd == ssp_pkg::CMD_BYTE) begin
      case (rx_phase)
        HUNT_FIRST: begin
          if (b == ssp_pkg::SYNC_BYTE) rx_phase = HUNT_SECOND;
        end
        HUNT_SECOND: begin
          rx_phase = (b == ssp_pkg::SYNC_BYTE) ? GET_ID : HUNT_FIRST;
        end
        GET_ID: begin
          rx_id = b;
          rx_sum = b;
          rx_phase = GET_LEN;
        end
        GET_LEN: begin
          rx_len = b;
          rx_sum = rx_sum + b;
          // no wrap in the size check: huge lengths are rejected too
          if (b < 8'd2 || int'(b) + 4 > PKT_MAX) begin
            rx_phase = HUNT_FIRST;
            push_report(ssp_pkg::ST_BAD_PACKET, 8'h00, 4'd0, 4'd0, 8'h00, 1'b1);
          end else begin
            rx_phase = GET_ERR;
          end
        end
        GET_ERR: begin
          rx_err = b;
          rx_sum = rx_sum + b;
          if (rx_id != cfg_id || n_par > cfg_cap || n_par > ssp_pkg::PARAM_DEPTH) begin
            rx_phase = HUNT_FIRST;
            push_report(ssp_pkg::ST_BAD_PACKET, 8'h00, 4'd0, 4'd0, 8'h00, 1'b1);
          end else begin
            rx_nparam = 4'd0;
            rx_phase = (n_par == 8'd0) ? GET_SUM : GET_PARAM;
          end
        end
        GET_PARAM: begin
          if (rx_nparam < ssp_pkg::PARAM_DEPTH) rx_buf[rx_nparam] = b;
          rx_sum = rx_sum + b;
          rx_nparam = rx_nparam + 4'd1;
          if (rx_nparam >= n_par) rx_phase = GET_SUM;
        end
        GET_SUM: begin
          rx_phase = HUNT_FIRST;
          if (~rx_sum != b) begin
            push_report(ssp_pkg::ST_BAD_CHECKSUM, 8'h00, 4'd0, 4'd0, 8'h00, 1'b1);
          end else begin
            st = (rx_err != 8'h00) ? ssp_pkg::ST_DEVICE : ssp_pkg::ST_OK;
            if (n_par == 8'd0) begin
              push_report(st, rx_err, 4'd0, 4'd0, 8'h00, 1'b1);
            end else begin
              for (i = 0; i < n_par; i++)
                push_report(st, rx_err, 4'(n_par), 4'(i), rx_buf[i], i == n_par - 1);
            end
          end
        end
        default: rx_phase = HUNT_FIRST;
      endcase
    end
  endtask

  function automatic void push_event(logic [1:0] cmd, logic [7:0] data);
    bus_events_q.push_back('{cmd, data});
    if (cmd != CMD_UNUSED) n_queued++;
  endfunction

  // Full packet with random parameters; a cut_at from 0 to below the packet size aborts it after that many bytes.
  function automatic void queue_packet(logic [7:0] id, int n, logic [7:0] err,
                                       bit bad_sum, int cut_at);
    logic [7:0] pkt_q[$];
    logic [7:0] sum;
    logic [7:0] len;
    logic [7:0] pb;
    int         i;
    len = 8'(n + 2);
    pkt_q = '{ssp_pkg::SYNC_BYTE, ssp_pkg::SYNC_BYTE, id, len, err};
    sum = id + len + err;
    for (i = 0; i < n; i++) begin
      pb = 8'($urandom);
      pkt_q.push_back(pb);
      sum = sum + pb;
    end
    pkt_q.push_back(bad_sum ? ~sum ^ (8'h01 << $urandom_range(0, 7)) : ~sum);
    if (cut_at >= 0 && cut_at < pkt_q.size()) begin
      pkt_q = pkt_q[0:cut_at-1];
      foreach (pkt_q[i]) push_event(ssp_pkg::CMD_BYTE, pkt_q[i]);
      push_event($urandom_range(0, 1) ? ssp_pkg::CMD_TIMEOUT : ssp_pkg::CMD_LINE_ERR,
                 8'($urandom));
    end else begin
      foreach (pkt_q[i]) push_event(ssp_pkg::CMD_BYTE, pkt_q[i]);
    end
  endfunction

  task automatic queue_random_traffic(input int target);
    int   start;
    int   r;
    int   n;
    int   cap_eff;
    logic [7:0] bad_len;
    start = n_queued;
    cap_eff = (cfg_cap > ssp_pkg::PARAM_DEPTH) ? ssp_pkg::PARAM_DEPTH : cfg_cap;
    queue_packet(cfg_id, cap_eff, 8'h00, 1'b0, -1);
    while (n_queued - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, cap_eff) : $urandom_range(0, 10);
        queue_packet(($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_id, n,
                     $urandom_range(0, 1) ? 8'($urandom) : 8'h00,
                     $urandom_range(0, 6) == 0, -1);
      end else if (r < 75) begin
        case ($urandom_range(0, 4))
          0: bad_len = 8'd0;
          1: bad_len = 8'd1;
          2: bad_len = 8'(PKT_MAX - 3);
          3: bad_len = 8'hFF;
          default: bad_len = 8'($urandom_range(PKT_MAX - 3, 255));
        endcase
        push_event(ssp_pkg::CMD_BYTE, ssp_pkg::SYNC_BYTE);
        push_event(ssp_pkg::CMD_BYTE, ssp_pkg::SYNC_BYTE);
        push_event(ssp_pkg::CMD_BYTE, cfg_id);
        push_event(ssp_pkg::CMD_BYTE, bad_len);
      end else if (r < 85) begin
        n = $urandom_range(0, cap_eff);
        queue_packet(cfg_id, n, 8'($urandom), 1'b0, $urandom_range(0, n + 5));
      end else begin
        push_event(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic sel, input logic [ssp_pkg::DATA_W-1:0] value);
    logic [ssp_pkg::ADDR_W-1:0] addr;
    addr = ssp_pkg::ADDR_W'(sel) << ssp_pkg::REG_SEL_BIT;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    // write done at the edge just passed; read it back
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== value) flag_mismatch("register read-back", prdata, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (sel == ssp_pkg::REG_TARGET_ID) cfg_id = value[7:0];
    else cfg_cap = value[3:0];
  endtask

  // Waits until every event is taken and every result has come, then lets
  // the parser finish any event that produces no result.
  task automatic settle();
    do @(posedge clk);
    while (bus_events_q.size() != 0 || in_valid || status_reports_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (bus_events_q.size() != 0) begin
        next_ev = bus_events_q.pop_front();
        command <= next_ev.cmd;
        rx_byte <= next_ev.data;
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYC - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        parse_rx_event(command, rx_byte);
        n_items++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (status_reports_q.size() == 0) begin
          flag_mismatch("result with none pending, status", status, 0);
        end else begin
          want = status_reports_q.pop_front();
          if (want.status < 6) seen_status[want.status]++;
          if (status !== want.status) flag_mismatch("status", status, want.status);
          if (device_error !== want.dev_err)
            flag_mismatch("device_error", device_error, want.dev_err);
          if (param_count !== want.count) flag_mismatch("param_count", param_count, want.count);
          if (param_index !== want.index) flag_mismatch("param_index", param_index, want.index);
          if (param_byte !== want.pbyte) flag_mismatch("param_byte", param_byte, want.pbyte);
          if (last !== want.last) flag_mismatch("last", last, want.last);
        end
      end
    end
  end

  // watchdog: cycles in which no item moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[%0t] watchdog: nothing accepted for %0d cycles", $time, QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: hunt restarts, ignored code, abort while hunting, empty packet,
    // short and wrapping lengths, 0xFF id vs configured id, over-capacity count
    push_event(ssp_pkg::CMD_BYTE, 8'h00);
    push_event(ssp_pkg::CMD_BYTE, ssp_pkg::SYNC_BYTE);
    push_event(ssp_pkg::CMD_BYTE, 8'h7F);
    push_event(CMD_UNUSED, 8'hA5);
    push_event(ssp_pkg::CMD_TIMEOUT, 8'h00);
    queue_packet(8'h00, 0, 8'h00, 1'b0, -1);
    push_event(ssp_pkg::CMD_BYTE, ssp_pkg::SYNC_BYTE);
    push_event(ssp_pkg::CMD_BYTE, ssp_pkg::SYNC_BYTE);
    push_event(ssp_pkg::CMD_BYTE, 8'h00);
    push_event(ssp_pkg::CMD_BYTE, 8'd1);
    push_event(ssp_pkg::CMD_BYTE, ssp_pkg::SYNC_BYTE);
    push_event(ssp_pkg::CMD_BYTE, ssp_pkg::SYNC_BYTE);
    push_event(ssp_pkg::CMD_BYTE, 8'h00);
    push_event(ssp_pkg::CMD_BYTE, 8'hFF);
    queue_packet(8'hFF, 0, 8'h00, 1'b0, -1);
    queue_packet(8'h00, 4, 8'h00, 1'b0, -1);
    push_event(ssp_pkg::CMD_LINE_ERR, 8'hFF);
    settle();

    write_reg(ssp_pkg::REG_TARGET_ID, 32'h00);
    write_reg(ssp_pkg::REG_PARAM_CAPACITY, 32'd0);
    n_settings++;
    queue_random_traffic(25);
    settle();

    // full buffer while the receiver holds off
    write_reg(ssp_pkg::REG_TARGET_ID, 32'hFF);
    write_reg(ssp_pkg::REG_PARAM_CAPACITY, 32'd10);
    n_settings++;
    holds_asked++;
    queue_random_traffic(25);
    settle();

    // capacity beyond the buffer depth, both sides back to back
    write_reg(ssp_pkg::REG_TARGET_ID, 32'h5A);
    write_reg(ssp_pkg::REG_PARAM_CAPACITY, 32'd15);
    n_settings++;
    no_gaps = 1'b1;
    queue_random_traffic(25);
    settle();
    no_gaps = 1'b0;

    write_reg(ssp_pkg::REG_TARGET_ID, 32'($urandom_range(0, 255)));
    write_reg(ssp_pkg::REG_PARAM_CAPACITY, 32'($urandom_range(0, 10)));
    n_settings++;
    queue_random_traffic(25);
    settle();

    $display("Ran %0d bus events and checked %0d results over %0d register settings.",
             n_items, n_results, n_settings);
    $display("Status mix ok/timeout/line/bad pkt/bad sum/device: %0d/%0d/%0d/%0d/%0d/%0d",
             seen_status[0], seen_status[1], seen_status[2], seen_status[3],
             seen_status[4], seen_status[5]);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ssp_pkg.sv
rtl/core/ssp_datapath.sv
rtl/core/ssp_ctrl.sv
rtl/core/servo_status_packet_parser.sv
tb/servo_status_packet_parser_tb.sv
